>>> rtl/fpa_pkg.sv
// Shared constants, codes and types of the fixed partition allocator.
package fpa_pkg;

  localparam int PARTITIONS_DEFAULT = 16;
  localparam int SIZE_BITS_DEFAULT  = 16;

  localparam int REQ_BITS       = 16;
  localparam int SLOT_BITS      = 4;
  localparam int MODE_BITS      = 2;
  localparam int COUNT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIT_POLICY      = 2'd0,
    CFG_PARTITION_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    POLICY_FIRST_FIT = 1'b0,
    POLICY_BEST_FIT  = 1'b1
  } policy_t;

  typedef struct packed {
    logic load;
    logic set_used;
    logic clr_used;
  } cell_cmd_t;

endpackage

>>> rtl/fixed_partition_allocator.sv
// Fixed partition allocator: a row of partition cells searched by a token passed cell to cell.
// Load and unused-mode results pass through the hold register to the result register.
// Allocate and free pass the token from start through each cell to the hold register.
// The token visits one cell per cycle. req_stall is high while a scan runs or a result waits.
// Synchronous active-high reset clears all sizes and in-use marks, sets first fit and 16.
// There is no clearing pass; the block accepts transactions in the cycle after reset.
module fixed_partition_allocator #(
  parameter int PARTITIONS = fpa_pkg::PARTITIONS_DEFAULT,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [fpa_pkg::MODE_BITS-1:0]       mode,
  input  logic [fpa_pkg::SLOT_BITS-1:0]       slot,
  input  logic [fpa_pkg::REQ_BITS-1:0]        request_size,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                granted,
  output logic [fpa_pkg::SLOT_BITS-1:0]       chosen_slot,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int IDX_BITS = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CMP_BITS = (SIZE_BITS > fpa_pkg::REQ_BITS) ? SIZE_BITS : fpa_pkg::REQ_BITS;

  logic                                fit_policy;
  logic [fpa_pkg::COUNT_BITS-1:0]      partition_count;

  logic                                scanning;
  logic                                start;
  logic [fpa_pkg::MODE_BITS-1:0]       op_mode;
  logic [CMP_BITS-1:0]                 op_req;
  logic                                hold_valid;
  logic                                hold_granted;
  logic [fpa_pkg::SLOT_BITS-1:0]       hold_slot;

  logic                                accept;
  logic                                is_scan;
  logic                                load_ok;
  logic [CMP_BITS-1:0]                 req_ext;
  logic [SIZE_BITS-1:0]                load_size;
  logic                                fin;
  logic                                out_free;

  logic [PARTITIONS:0]                 tok_valid;
  logic [PARTITIONS:0]                 tok_found;
  logic [IDX_BITS-1:0]                 tok_pick [PARTITIONS+1];
  logic [CMP_BITS-1:0]                 tok_best [PARTITIONS+1];
  fpa_pkg::cell_cmd_t                  cmd [PARTITIONS];

  assign cfg_ready = 1'b1;
  assign req_stall = scanning || start || hold_valid;
  assign accept    = req_valid && !req_stall;
  assign is_scan   = (mode == fpa_pkg::MODE_ALLOC) || (mode == fpa_pkg::MODE_FREE);
  assign load_ok   = (mode == fpa_pkg::MODE_LOAD) && (32'(slot) < PARTITIONS);
  assign req_ext   = CMP_BITS'(request_size);
  assign load_size = req_ext[SIZE_BITS-1:0];
  assign fin       = tok_valid[PARTITIONS];
  assign out_free  = !rsp_valid || !rsp_stall;

  assign tok_valid[0] = start;
  assign tok_found[0] = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_best[0]  = '0;

  for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
    always_comb begin
      cmd[i].load     = accept && load_ok && (32'(slot) == i);
      cmd[i].set_used = fin && tok_found[PARTITIONS] && (op_mode == fpa_pkg::MODE_ALLOC)
                        && (tok_pick[PARTITIONS] == IDX_BITS'(i));
      cmd[i].clr_used = fin && tok_found[PARTITIONS] && (op_mode == fpa_pkg::MODE_FREE)
                        && (tok_pick[PARTITIONS] == IDX_BITS'(i));
    end

    fpa_cell #(
      .SIZE_BITS (SIZE_BITS),
      .CMP_BITS  (CMP_BITS),
      .IDX_BITS  (IDX_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .count         (partition_count),
      .policy        (fit_policy),
      .op_mode       (op_mode),
      .op_req        (op_req),
      .cmd           (cmd[i]),
      .load_size     (load_size),
      .tok_in_valid  (tok_valid[i]),
      .tok_in_found  (tok_found[i]),
      .tok_in_pick   (tok_pick[i]),
      .tok_in_best   (tok_best[i]),
      .tok_out_valid (tok_valid[i+1]),
      .tok_out_found (tok_found[i+1]),
      .tok_out_pick  (tok_pick[i+1]),
      .tok_out_best  (tok_best[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy      <= fpa_pkg::POLICY_FIRST_FIT;
      partition_count <= fpa_pkg::COUNT_BITS'(16);
      scanning        <= 1'b0;
      start           <= 1'b0;
      hold_valid      <= 1'b0;
      rsp_valid       <= 1'b0;
      op_mode         <= '0;
      op_req          <= '0;
      hold_granted    <= 1'b0;
      hold_slot       <= '0;
      granted         <= 1'b0;
      chosen_slot     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fpa_pkg::CFG_FIT_POLICY:      fit_policy      <= cfg_data[0];
          fpa_pkg::CFG_PARTITION_COUNT: partition_count <= cfg_data;
          default: ;
        endcase
      end

      start <= accept && is_scan;
      if (accept) begin
        op_mode <= mode;
        op_req  <= req_ext;
      end

      if (accept && is_scan) begin
        scanning <= 1'b1;
      end else if (fin) begin
        scanning <= 1'b0;
      end

      if (fin) begin
        hold_valid   <= 1'b1;
        hold_granted <= tok_found[PARTITIONS];
        hold_slot    <= tok_found[PARTITIONS]
                        ? fpa_pkg::SLOT_BITS'(tok_pick[PARTITIONS]) : '0;
      end else if (accept && !is_scan) begin
        hold_valid   <= 1'b1;
        hold_granted <= load_ok;
        hold_slot    <= load_ok ? slot : '0;
      end else if (hold_valid && out_free) begin
        hold_valid <= 1'b0;
      end

      if (out_free) begin
        rsp_valid <= hold_valid;
        if (hold_valid) begin
          granted     <= hold_granted;
          chosen_slot <= hold_slot;
        end
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_valid))
    else $error("More than one search token in the cell row.");

  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst) fin |-> scanning)
    else $error("Search token finished outside a scan.");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !granted) |-> (chosen_slot == '0))
    else $error("Refused transaction carries a nonzero slot.");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    start |=> (scanning && !hold_valid))
    else $error("Scan started without the block marked busy.");

endmodule

>>> rtl/fpa_cell.sv
// One partition cell: holds a size and an in-use mark and passes the search token on.
module fpa_cell #(
  parameter int SIZE_BITS = fpa_pkg::SIZE_BITS_DEFAULT,
  parameter int CMP_BITS  = fpa_pkg::REQ_BITS,
  parameter int IDX_BITS  = 4,
  parameter int INDEX     = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fpa_pkg::COUNT_BITS-1:0]  count,
  input  logic                            policy,
  input  logic [fpa_pkg::MODE_BITS-1:0]   op_mode,
  input  logic [CMP_BITS-1:0]             op_req,
  input  fpa_pkg::cell_cmd_t              cmd,
  input  logic [SIZE_BITS-1:0]            load_size,
  input  logic                            tok_in_valid,
  input  logic                            tok_in_found,
  input  logic [IDX_BITS-1:0]             tok_in_pick,
  input  logic [CMP_BITS-1:0]             tok_in_best,
  output logic                            tok_out_valid,
  output logic                            tok_out_found,
  output logic [IDX_BITS-1:0]             tok_out_pick,
  output logic [CMP_BITS-1:0]             tok_out_best
);

  logic [SIZE_BITS-1:0] size;
  logic                 used;
  logic [CMP_BITS-1:0]  size_ext;
  logic [CMP_BITS-1:0]  diff;
  logic                 active;
  logic                 fits;
  logic                 take;

  assign size_ext = CMP_BITS'(size);
  assign diff     = size_ext - op_req;
  assign active   = 32'(count) > INDEX;
  assign fits     = active && !used && (size_ext >= op_req);

  always_comb begin
    take = 1'b0;
    if (op_mode == fpa_pkg::MODE_ALLOC) begin
      if (policy == fpa_pkg::POLICY_FIRST_FIT) begin
        take = fits && !tok_in_found;
      end else begin
        take = fits && (!tok_in_found || (diff < tok_in_best));
      end
    end else if (op_mode == fpa_pkg::MODE_FREE) begin
      take = active && used && (size_ext == op_req) && !tok_in_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size          <= '0;
      used          <= 1'b0;
      tok_out_valid <= 1'b0;
      tok_out_found <= 1'b0;
      tok_out_pick  <= '0;
      tok_out_best  <= '0;
    end else begin
      if (cmd.load) begin
        size <= load_size;
        used <= 1'b0;
      end else if (cmd.set_used) begin
        used <= 1'b1;
      end else if (cmd.clr_used) begin
        used <= 1'b0;
      end
      tok_out_valid <= tok_in_valid;
      if (tok_in_valid && take) begin
        tok_out_found <= 1'b1;
        tok_out_pick  <= IDX_BITS'(INDEX);
        tok_out_best  <= diff;
      end else begin
        tok_out_found <= tok_in_found;
        tok_out_pick  <= tok_in_pick;
        tok_out_best  <= tok_in_best;
      end
    end
  end

endmodule

>>> sim/tb_fixed_partition_allocator.sv
// Self-checking testbench for the fixed partition allocator with directed and random tests.
`timescale 1ns / 100ps

module tb_fixed_partition_allocator;
  import fpa_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                 granted;
    logic [SLOT_BITS-1:0] slot;
  } grant_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  logic [MODE_BITS-1:0]      mode = '0;
  logic [SLOT_BITS-1:0]      slot = '0;
  logic [REQ_BITS-1:0]       request_size = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic                      granted;
  logic [SLOT_BITS-1:0]      chosen_slot;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic [REQ_BITS-1:0]   model_size [TABLE_SLOTS];
  bit                    model_used [TABLE_SLOTS];
  policy_t               model_policy;
  logic [COUNT_BITS-1:0] model_count;
  grant_t                pending_grants [$];
  int                    fault_count = 0;
  int unsigned           cycle_count = 0;
  int                    burst_left = 0;
  bit                    sender_gaps = 1'b1;
  logic [9:0]            stall_tick = '0;

  fixed_partition_allocator u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .mode         (mode),
    .slot         (slot),
    .request_size (request_size),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted      (granted),
    .chosen_slot  (chosen_slot),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic grant_t predict_grant(input logic [MODE_BITS-1:0] op,
                                           input logic [SLOT_BITS-1:0] where,
                                           input logic [REQ_BITS-1:0] amount);
    grant_t              res;
    int                  span;
    int                  pick;
    bit                  found;
    logic [REQ_BITS-1:0] leftover;
    logic [REQ_BITS-1:0] best;
    res = '0;
    span = (model_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(model_count);
    pick = 0;
    found = 1'b0;
    best = '0;
    case (op)
      MODE_LOAD: begin
        model_size[where] = amount;
        model_used[where] = 1'b0;
        res.granted = 1'b1;
        res.slot = where;
      end
      MODE_ALLOC: begin
        for (int i = 0; i < span; i++) begin
          if (!model_used[i] && model_size[i] >= amount &&
              !(found && model_policy == POLICY_FIRST_FIT)) begin
            leftover = model_size[i] - amount;
            if (!found || leftover < best) begin
              found = 1'b1;
              best = leftover;
              pick = i;
            end
          end
        end
      end
      MODE_FREE: begin
        for (int i = 0; i < span; i++) begin
          if (!found && model_used[i] && model_size[i] == amount) begin
            found = 1'b1;
            pick = i;
          end
        end
      end
      default: ;
    endcase
    if (found) begin
      model_used[pick] = (op == MODE_ALLOC);
      res.granted = 1'b1;
      res.slot = SLOT_BITS'(pick);
    end
    return res;
  endfunction

  task automatic send_op(input logic [MODE_BITS-1:0] op, input logic [SLOT_BITS-1:0] where,
                         input logic [REQ_BITS-1:0] amount);
    bit taken;
    taken = 1'b0;
    req_valid = 1'b1;
    mode = op;
    slot = where;
    request_size = amount;
    while (!taken) begin
      @(posedge clk);
      taken = !req_stall;
    end
    pending_grants.push_back(predict_grant(op, where, amount));
    @(negedge clk);
    if (sender_gaps && burst_left == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 22)) @(negedge clk);
      burst_left = $urandom_range(0, 9);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic drain_pending();
    req_valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input cfg_reg_t index, input logic [CFG_DATA_BITS-1:0] value);
    bit taken;
    taken = 1'b0;
    drain_pending();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    if (index == CFG_FIT_POLICY) model_policy = policy_t'(value[0]);
    else model_count = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_reset_state();
    send_op(MODE_ALLOC, 4'd0, 16'd0);
    send_op(MODE_ALLOC, 4'd0, 16'd1);
    send_op(MODE_FREE, 4'd0, 16'd0);
  endtask

  task automatic test_load();
    send_op(MODE_LOAD, 4'd0, 16'h5555);
    send_op(MODE_LOAD, 4'd15, 16'hFFFF);
    send_op(MODE_LOAD, 4'd1, 16'd100);
    send_op(MODE_LOAD, 4'd2, 16'd40);
    send_op(MODE_LOAD, 4'd3, 16'd60);
    send_op(MODE_LOAD, 4'd4, 16'd40);
    send_op(MODE_LOAD, 4'd10, 16'hAAAA);
  endtask

  task automatic test_first_fit();
    send_op(MODE_ALLOC, 4'd0, 16'd50);
    send_op(MODE_ALLOC, 4'd0, 16'd50);
  endtask

  task automatic test_best_fit();
    write_register(CFG_FIT_POLICY, CFG_DATA_BITS'(POLICY_BEST_FIT));
    send_op(MODE_ALLOC, 4'd0, 16'd41);
    send_op(MODE_ALLOC, 4'd0, 16'd40);
    send_op(MODE_ALLOC, 4'd0, 16'hFFFF);
  endtask

  task automatic test_free_by_size();
    send_op(MODE_FREE, 4'd0, 16'd40);
    send_op(MODE_FREE, 4'd0, 16'd40);
    send_op(MODE_FREE, 4'd0, 16'd100);
  endtask

  task automatic test_unused_mode();
    send_op(MODE_UNUSED, 4'd15, 16'hFFFF);
  endtask

  task automatic test_partition_count();
    write_register(CFG_PARTITION_COUNT, 5'd0);
    send_op(MODE_ALLOC, 4'd0, 16'd0);
    send_op(MODE_LOAD, 4'd5, 16'd7);
    write_register(CFG_PARTITION_COUNT, 5'd15);
    send_op(MODE_FREE, 4'd0, 16'hFFFF);
    write_register(CFG_PARTITION_COUNT, 5'd31);
    send_op(MODE_FREE, 4'd0, 16'hFFFF);
  endtask

  task automatic test_random();
    int                   items;
    int                   roll;
    int                   j;
    bit                   wide;
    logic [MODE_BITS-1:0] op;
    logic [SLOT_BITS-1:0] where;
    logic [REQ_BITS-1:0]  amount;
    for (int phase = 0; phase < 8; phase++) begin
      write_register(CFG_FIT_POLICY, CFG_DATA_BITS'(phase % 2));
      case (phase)
        2: write_register(CFG_PARTITION_COUNT, 5'd0);
        3: write_register(CFG_PARTITION_COUNT, 5'd31);
        4: write_register(CFG_PARTITION_COUNT, 5'd1);
        6: write_register(CFG_PARTITION_COUNT, 5'd16);
        default: write_register(CFG_PARTITION_COUNT, CFG_DATA_BITS'($urandom_range(2, 20)));
      endcase
      sender_gaps = (phase != 5);
      wide = (phase % 3 == 1);
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        send_op(MODE_LOAD, SLOT_BITS'(s),
                wide ? REQ_BITS'($urandom) : REQ_BITS'($urandom_range(1, 40)));
      end
      items = (phase == 2) ? 50 : 210;
      repeat (items) begin
        roll = $urandom_range(0, 99);
        j = $urandom_range(0, TABLE_SLOTS - 1);
        where = SLOT_BITS'(j);
        if (roll < 45) begin
          op = MODE_ALLOC;
          case ($urandom_range(0, 3))
            0, 1: amount = model_size[j] - REQ_BITS'($urandom_range(0, 2));
            2: amount = REQ_BITS'($urandom_range(0, 48));
            default: amount = REQ_BITS'($urandom);
          endcase
        end else if (roll < 80) begin
          op = MODE_FREE;
          amount = REQ_BITS'($urandom_range(0, 48));
          if ($urandom_range(0, 4) != 0) begin
            for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
              if (model_used[(j + k) % TABLE_SLOTS]) amount = model_size[(j + k) % TABLE_SLOTS];
            end
          end
        end else if (roll < 93) begin
          op = MODE_LOAD;
          amount = (wide || $urandom_range(0, 7) == 0) ? REQ_BITS'($urandom)
                                                      : REQ_BITS'($urandom_range(0, 40));
        end else begin
          op = MODE_BITS'($urandom_range(0, 3));
          amount = REQ_BITS'($urandom);
        end
        send_op(op, where, amount);
      end
    end
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= ($urandom_range(0, 2) == 0);
      2'd2: rsp_stall <= (stall_tick[2:0] < 3'd3);
      default: rsp_stall <= ($urandom_range(0, 2) != 0);
    endcase
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_grants.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: transaction with none outstanding: granted=%0b chosen_slot=%0d",
                   $time, granted, chosen_slot);
      end else begin
        want = pending_grants.pop_front();
        if (granted !== want.granted || chosen_slot !== want.slot) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: expected granted=%0b chosen_slot=%0d, got granted=%0b chosen_slot=%0d",
                     $time, want.granted, want.slot, granted, chosen_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** fixed_partition_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      model_size[i] = '0;
      model_used[i] = 1'b0;
    end
    model_policy = POLICY_FIRST_FIT;
    model_count = 5'd16;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_load();
    test_first_fit();
    test_best_fit();
    test_free_by_size();
    test_unused_mode();
    test_partition_count();
    test_random();
    drain_pending();
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("** fixed_partition_allocator: PASSED **");
    end else begin
      $display("** fixed_partition_allocator: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fixed_partition_allocator.sv
sim/tb_fixed_partition_allocator.sv
